// ----- src/nau_pkg.sv -----
// ----------------------------------------------------------------------------
// nau_pkg
// Shared widths, register indexes, activation kinds and the sigmoid table of
// the neural activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int DataWidth  = 16;
  localparam int FracBits   = 12;
  localparam int TableDepth = 256;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int LowBits    = FracBits + 4 - IdxBits;
  localparam int ArgW       = DataWidth + 2;
  localparam int SigW       = 32;
  localparam int ProdW      = SigW + LowBits + 2;
  localparam int TW         = SigW + 2;
  localparam int YW         = DataWidth + 2;
  localparam int SlopeW     = 12;
  localparam int LeakW      = DataWidth + SlopeW + 1;
  localparam int FwdShift   = 31 - FracBits;
  localparam int DerShift   = 62 - FracBits;
  localparam int SlopeShift = FracBits - 12;
  localparam int KindW      = 3;
  localparam int CfgIdxW    = 2;

  localparam logic [SlopeW-1:0] SlopeReset = SlopeW'(41);

  localparam logic [CfgIdxW-1:0] CFG_KIND  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_SLOPE = CfgIdxW'(1);

  typedef enum logic [KindW-1:0] {
    KIND_SIGMOID = 3'd0,
    KIND_RELU    = 3'd1,
    KIND_LEAKY   = 3'd2,
    KIND_TANH    = 3'd3,
    KIND_LINEAR  = 3'd4
  } kind_e;

  localparam logic signed [ArgW-1:0]  ArgOffset  = ArgW'(1) << (FracBits + 3);
  localparam logic signed [ProdW-1:0] InterpHalf = ProdW'(1) << (LowBits - 1);
  localparam logic signed [TW-1:0]    TOne       = TW'(1) << 31;
  localparam logic signed [TW-1:0]    FwdHalf    = TW'(1) << (FwdShift - 1);
  localparam logic [63:0]             DerHalf    = 64'(1) << (DerShift - 1);
  localparam logic [63:0]             QOne62     = 64'(1) << 62;
  localparam logic [SigW-1:0]         QOne31     = SigW'(1) << 31;
  localparam logic signed [LeakW-1:0] LeakHalf   = LeakW'(1) << 11;
  localparam logic signed [YW-1:0]    YOne       = YW'(1) << FracBits;
  localparam logic signed [YW-1:0]    YMax       = (YW'(1) << (DataWidth - 1)) - YW'(1);
  localparam logic signed [YW-1:0]    YMin       = -(YW'(1) << (DataWidth - 1));

  // Sideband that travels with every item down the pipeline.
  typedef struct packed {
    logic                        op;
    logic [KindW-1:0]            kind;
    logic signed [DataWidth-1:0] x;
  } side_t;

  typedef logic [SigW-1:0] sig_tab_t [TableDepth+1];

  localparam longint Q31One = 64'sd1 <<< 31;

  // Quotient of two non-negative values by shift and subtract.
  function automatic longint long_div(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q31 for f in [0, 1.0], truncated Taylor series.
  function automatic longint exp_frac(longint f);
    longint term;
    longint sum;
    term = Q31One;
    sum  = Q31One;
    for (int k = 1; k <= 24; k++) begin
      term = long_div((term * f) >>> 31, longint'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q31One) begin
      sum = Q31One;
    end
    return sum;
  endfunction

  // exp(-u) in Q31 for u in Q31 between 0 and 8.0.
  function automatic longint exp_neg(longint u);
    longint em1;
    longint r;
    longint whole;
    em1   = exp_frac(Q31One);
    r     = exp_frac(u & (Q31One - 1));
    whole = u >>> 31;
    for (longint j = 0; j < whole; j++) begin
      r = (r * em1 + (64'sd1 <<< 30)) >>> 31;
    end
    return r;
  endfunction

  // Sigmoid at evenly spaced points over [-8, 8], unsigned Q1.31.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    longint   d;
    longint   ad;
    longint   u;
    longint   e;
    longint   s;
    for (int i = 0; i <= TableDepth; i++) begin
      d  = 16 * longint'(i) - 8 * longint'(TableDepth);
      ad = (d < 0) ? -d : d;
      u  = (ad * Q31One) >>> IdxBits;
      e  = exp_neg(u);
      s  = long_div(64'sd1 <<< 62, Q31One + e);
      tab[i] = (d >= 0) ? SigW'(s) : SigW'(Q31One - s);
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTable = build_sig_table();

endpackage

// ----- src/nau_lookup.sv -----
// ----------------------------------------------------------------------------
// nau_lookup
// Forms the table address from the input value and reads the two sigmoid
// points around it. Two register stages.
// ----------------------------------------------------------------------------
module nau_lookup import nau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  side_t             side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output side_t             side_o,
  output logic [SigW-1:0]   t0_o,
  output logic [SigW-1:0]   t1_o,
  output logic [LowBits-1:0] fr_o
);

  logic signed [ArgW-1:0] xs, arg, v;
  logic                   lo, hi;

  logic                   a_valid_q;
  side_t                  a_side_q;
  logic [IdxBits-1:0]     a_idx_q;
  logic [LowBits-1:0]     a_fr_q;
  logic                   a_lo_q, a_hi_q;

  logic                   b_valid_q;
  side_t                  b_side_q;
  logic [SigW-1:0]        b_t0_q, b_t1_q, b_t0_d;
  logic [LowBits-1:0]     b_fr_q, b_fr_d;
  logic [IdxBits:0]       idx1;
  logic                   adv_a, adv_b;

  assign xs  = {{(ArgW-DataWidth){side_i.x[DataWidth-1]}}, side_i.x};
  assign arg = (side_i.kind == KIND_TANH) ? (xs <<< 1) : xs;
  assign v   = arg + ArgOffset;
  assign lo  = v[ArgW-1];
  assign hi  = !lo && (v[ArgW-2:LowBits+IdxBits] != '0);

  assign adv_b      = !b_valid_q || out_ready_i;
  assign adv_a      = !a_valid_q || adv_b;
  assign in_ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= in_valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      a_side_q <= side_i;
      a_idx_q  <= v[LowBits+IdxBits-1:LowBits];
      a_fr_q   <= v[LowBits-1:0];
      a_lo_q   <= lo;
      a_hi_q   <= hi;
    end
  end

  assign idx1 = {1'b0, a_idx_q} + (IdxBits+1)'(1);

  always_comb begin
    b_t0_d = SigTable[{1'b0, a_idx_q}];
    b_fr_d = a_fr_q;
    if (a_lo_q) begin
      b_t0_d = SigTable[0];
      b_fr_d = '0;
    end else if (a_hi_q) begin
      b_t0_d = SigTable[TableDepth];
      b_fr_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b && a_valid_q) begin
      b_side_q <= a_side_q;
      b_t0_q   <= b_t0_d;
      b_t1_q   <= SigTable[idx1];
      b_fr_q   <= b_fr_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign side_o      = b_side_q;
  assign t0_o        = b_t0_q;
  assign t1_o        = b_t1_q;
  assign fr_o        = b_fr_q;

endmodule

// ----- src/nau_interp.sv -----
// ----------------------------------------------------------------------------
// nau_interp
// Linear interpolation between two sigmoid points: a multiply stage and a
// round-and-add stage.
// ----------------------------------------------------------------------------
module nau_interp import nau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  side_t              side_i,
  input  logic [SigW-1:0]    t0_i,
  input  logic [SigW-1:0]    t1_i,
  input  logic [LowBits-1:0] fr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output side_t              side_o,
  output logic [SigW-1:0]    s_o
);

  logic signed [SigW:0]    diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] rnd;
  logic signed [SigW+1:0]  s_wide;

  logic                    c_valid_q;
  side_t                   c_side_q;
  logic signed [ProdW-1:0] c_prod_q;
  logic [SigW-1:0]         c_t0_q;

  logic                    d_valid_q;
  side_t                   d_side_q;
  logic [SigW-1:0]         d_s_q;
  logic                    adv_c, adv_d;

  assign diff = $signed({1'b0, t1_i}) - $signed({1'b0, t0_i});
  assign prod = ProdW'(diff) * ProdW'($signed({1'b0, fr_i}));

  assign rnd    = (c_prod_q + InterpHalf) >>> LowBits;
  assign s_wide = $signed({2'b00, c_t0_q}) + rnd[SigW+1:0];

  assign adv_d      = !d_valid_q || out_ready_i;
  assign adv_c      = !c_valid_q || adv_d;
  assign in_ready_o = adv_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (adv_c) begin
        c_valid_q <= in_valid_i;
      end
      if (adv_d) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_c && in_valid_i) begin
      c_side_q <= side_i;
      c_prod_q <= prod;
      c_t0_q   <= t0_i;
    end
    if (adv_d && c_valid_q) begin
      d_side_q <= c_side_q;
      d_s_q    <= s_wide[SigW-1:0];
    end
  end

  assign out_valid_o = d_valid_q;
  assign side_o      = d_side_q;
  assign s_o         = d_s_q;

endmodule

// ----- src/nau_post.sv -----
// ----------------------------------------------------------------------------
// nau_post
// Derivative products, leaky scaling, final selection, rounding and
// saturation. The last stage is the output register.
// ----------------------------------------------------------------------------
module nau_post import nau_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [SlopeW-1:0]           slope_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  side_t                       side_i,
  input  logic [SigW-1:0]             s_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] y_o
);

  logic signed [TW-1:0]    t, abs_t, fwd_sig, fwd_tanh;
  logic [SigW-1:0]         opa, opb;
  logic signed [LeakW-1:0] leak;

  logic                    e_valid_q;
  side_t                   e_side_q;
  logic [63:0]             e_prod_q;
  logic signed [YW-1:0]    e_fwd_q;
  logic signed [LeakW-1:0] e_leak_q;

  logic [63:0]             der_sig, der_tanh;
  logic signed [LeakW-1:0] leak_r;
  logic                    x_pos;
  logic signed [YW-1:0]    x_ext, slope_ext, y_wide, y_sat;

  logic                    f_valid_q;
  logic signed [DataWidth-1:0] f_y_q;
  logic                    adv_e, adv_f;

  assign t        = $signed({1'b0, s_i, 1'b0}) - TOne;
  assign abs_t    = t[TW-1] ? -t : t;
  assign fwd_sig  = ($signed({2'b00, s_i}) + FwdHalf) >>> FwdShift;
  assign fwd_tanh = (t + FwdHalf) >>> FwdShift;
  assign opa      = (side_i.kind == KIND_TANH) ? abs_t[SigW-1:0] : s_i;
  assign opb      = (side_i.kind == KIND_TANH) ? abs_t[SigW-1:0] : (QOne31 - s_i);
  assign leak     = LeakW'(side_i.x) * LeakW'($signed({1'b0, slope_i}));

  assign adv_f      = !f_valid_q || out_ready_i;
  assign adv_e      = !e_valid_q || adv_f;
  assign in_ready_o = adv_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (adv_e) begin
        e_valid_q <= in_valid_i;
      end
      if (adv_f) begin
        f_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_e && in_valid_i) begin
      e_side_q <= side_i;
      e_prod_q <= 64'(opa) * 64'(opb);
      e_fwd_q  <= (side_i.kind == KIND_TANH) ? fwd_tanh[YW-1:0] : fwd_sig[YW-1:0];
      e_leak_q <= leak;
    end
  end

  assign der_sig   = (e_prod_q + DerHalf) >> DerShift;
  assign der_tanh  = (QOne62 - e_prod_q + DerHalf) >> DerShift;
  assign leak_r    = (e_leak_q + LeakHalf) >>> 12;
  assign x_pos     = !e_side_q.x[DataWidth-1] && (e_side_q.x != '0);
  assign x_ext     = {{(YW-DataWidth){e_side_q.x[DataWidth-1]}}, e_side_q.x};
  assign slope_ext = YW'({1'b0, slope_i}) << SlopeShift;

  always_comb begin
    case (e_side_q.kind)
      KIND_SIGMOID: y_wide = e_side_q.op ? $signed(der_sig[YW-1:0]) : e_fwd_q;
      KIND_RELU: begin
        if (e_side_q.op) begin
          y_wide = x_pos ? YOne : '0;
        end else begin
          y_wide = x_pos ? x_ext : '0;
        end
      end
      KIND_LEAKY: begin
        if (e_side_q.op) begin
          y_wide = x_pos ? YOne : slope_ext;
        end else begin
          y_wide = x_pos ? x_ext : leak_r[YW-1:0];
        end
      end
      KIND_TANH:   y_wide = e_side_q.op ? $signed(der_tanh[YW-1:0]) : e_fwd_q;
      KIND_LINEAR: y_wide = e_side_q.op ? YOne : x_ext;
      default:     y_wide = '0;
    endcase
  end

  assign y_sat = (y_wide > YMax) ? YMax : ((y_wide < YMin) ? YMin : y_wide);

  always_ff @(posedge clk_i) begin
    if (adv_f && e_valid_q) begin
      f_y_q <= y_sat[DataWidth-1:0];
    end
  end

  assign out_valid_o = f_valid_q;
  assign y_o         = f_y_q;

endmodule

// ----- src/neural_activation_unit.sv -----
// ----------------------------------------------------------------------------
// neural_activation_unit
// Sigmoid, ReLU, leaky ReLU, tanh and linear activations and their
// derivatives on signed Q4.12 values, sigmoid by table and interpolation.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   operation_i, x_value_i
//   out      output     out_valid_o/out_ready_i y_value_o
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Six register stages: address, table read, interpolation multiply, add,
// derivative multiply, output register. One transfer is taken every cycle
// while the output is not stalled. Reset clears only the stage valid bits and
// the two configuration registers. A stall at the output holds each stage
// that is full, while empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
module neural_activation_unit import nau_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_idx_i,
  input  logic [SlopeW-1:0]           cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic signed [DataWidth-1:0] x_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] y_value_o
);

  logic [KindW-1:0]   kind_q;
  logic [SlopeW-1:0]  slope_q;

  side_t              in_side;
  side_t              lk_side, ip_side;
  logic               lk_valid, lk_ready, ip_valid, ip_ready;
  logic [SigW-1:0]    lk_t0, lk_t1, ip_s;
  logic [LowBits-1:0] lk_fr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_SIGMOID;
      slope_q <= SlopeReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KIND) begin
        kind_q <= cfg_data_i[KindW-1:0];
      end else if (cfg_idx_i == CFG_SLOPE) begin
        slope_q <= cfg_data_i;
      end
    end
  end

  assign in_side.op   = operation_i;
  assign in_side.kind = kind_q;
  assign in_side.x    = x_value_i;

  nau_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .side_i      (in_side),
    .out_valid_o (lk_valid),
    .out_ready_i (lk_ready),
    .side_o      (lk_side),
    .t0_o        (lk_t0),
    .t1_o        (lk_t1),
    .fr_o        (lk_fr)
  );

  nau_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lk_valid),
    .in_ready_o  (lk_ready),
    .side_i      (lk_side),
    .t0_i        (lk_t0),
    .t1_i        (lk_t1),
    .fr_i        (lk_fr),
    .out_valid_o (ip_valid),
    .out_ready_i (ip_ready),
    .side_o      (ip_side),
    .s_o         (ip_s)
  );

  nau_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slope_i     (slope_q),
    .in_valid_i  (ip_valid),
    .in_ready_o  (ip_ready),
    .side_i      (ip_side),
    .s_i         (ip_s),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .y_o         (y_value_o)
  );

endmodule
